>>> design/tccw_pkg.sv
// Shared types, codes and tables for the text console cell writer.
package tccw_pkg;

    // Default console geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int HEXCNT_W = 4;
    localparam int INDEX_W  = 11;
    localparam int CELL_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int POWIDX_W = 4;

    // Packed stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Character and attribute constants
    localparam logic [CHAR_W-1:0] ATTRIBUTE  = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [POWIDX_W-1:0] POW_TOP  = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // Item action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CHAR = 2'd0,
        ACT_HEX  = 2'd1,
        ACT_DEC  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_PFX0,
        ST_PFXX,
        ST_HEX,
        ST_DEC
    } state_t;

    // Cursor controls
    typedef struct packed {
        logic advance;
        logic newline;
    } cur_ctrl_t;

    // Decimal unit controls and status
    typedef struct packed {
        logic load;
        logic step;
    } dec_ctrl_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               emit;
        logic               last;
    } dec_stat_t;

    // Powers of ten used by the digit unit
    function automatic logic [VALUE_W-1:0] pow10(input logic [POWIDX_W-1:0] idx);
        logic [VALUE_W-1:0] p;
        case (idx)
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    // Upper-case hex glyph
    function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
        logic [CHAR_W-1:0] g;
        if (nib < 4'd10) begin
            g = CHAR_ZERO + {4'h0, nib};
        end else begin
            g = 8'h37 + {4'h0, nib};
        end
        return g;
    endfunction

endpackage

>>> design/tccw_cursor.sv
// Cursor column and row with a running row base for the cell index.
module tccw_cursor #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tccw_pkg::cur_ctrl_t            ctrl,
    output logic [tccw_pkg::INDEX_W-1:0]   cell_index
);

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [tccw_pkg::INDEX_W-1:0] ROW_STEP = tccw_pkg::INDEX_W'(COLUMNS);

    logic [COL_W-1:0]              col_reg, col_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [tccw_pkg::INDEX_W-1:0]  base_reg, base_next;
    logic                          wrap;

    // Move to a new row on newline or at the end of a row
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        wrap      = ctrl.newline || (ctrl.advance && col_reg == COL_LAST);
        if (wrap) begin
            col_next = '0;
            if (row_reg == ROW_LAST) begin
                row_next  = '0;
                base_next = '0;
            end else begin
                row_next  = row_reg + 1'b1;
                base_next = base_reg + ROW_STEP;
            end
        end else if (ctrl.advance) begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

    assign cell_index = base_reg + tccw_pkg::INDEX_W'(col_reg);

    // Column never passes the last one
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_LAST)
        else $error("cursor column out of range");

    // Row base returns to zero together with the row
    a_base_row: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg == '0 |-> base_reg == '0)
        else $error("row base out of step with row");

endmodule

>>> design/tccw_dec_unit.sv
// Decimal digit unit: one shared compare and subtract against powers of ten.
module tccw_dec_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tccw_pkg::dec_ctrl_t             ctrl,
    input  logic [tccw_pkg::VALUE_W-1:0]    load_value,
    output tccw_pkg::dec_stat_t             stat
);

    logic [tccw_pkg::VALUE_W-1:0]   rem_reg, rem_next;
    logic [tccw_pkg::POWIDX_W-1:0]  idx_reg, idx_next;
    logic [tccw_pkg::DIGIT_W-1:0]   digit_reg, digit_next;
    logic                           started_reg, started_next;
    logic [tccw_pkg::VALUE_W-1:0]   pow;
    logic                           ge;

    // Compare remainder with the current power of ten
    always_comb begin
        pow        = tccw_pkg::pow10(idx_reg);
        ge         = rem_reg >= pow;
        stat.digit = digit_reg;
        stat.emit  = !ge && (started_reg || digit_reg != '0 || idx_reg == '0);
        stat.last  = !ge && idx_reg == '0;
    end

    // Subtract while possible, else close the digit and drop to the next power
    always_comb begin
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        digit_next   = digit_reg;
        started_next = started_reg;
        if (ctrl.load) begin
            rem_next     = load_value;
            idx_next     = tccw_pkg::POW_TOP;
            digit_next   = '0;
            started_next = 1'b0;
        end else if (ctrl.step) begin
            if (ge) begin
                rem_next   = rem_reg - pow;
                digit_next = digit_reg + 1'b1;
            end else begin
                digit_next   = '0;
                started_next = started_reg || stat.emit;
                if (idx_reg != '0) begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            digit_reg   <= '0;
            started_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            digit_reg   <= digit_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    // A digit never counts past nine
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_reg <= tccw_pkg::DIGIT_MAX)
        else $error("decimal digit above nine");

endmodule

>>> design/text_console_cell_writer_top.sv
// Text console cell writer: sequencer, output register and submodules.
//
//  channel | dir | tdata (low bit up)                      | tuser  | tlast
//  s_      | in  | value[31:0], hex_digits[35:32], pad     | action | -
//  m_      | out | cell_index[10:0], cell_value[26:11], pad | -      | last_cell
//
// After the accept cycle, a character writes one cell, a hex item writes the
// 0x prefix and then its digits, and a decimal item steps the shared compare
// and subtract unit, which subtracts a power of ten while it can and then
// drops to the next power. A newline or unused action finishes in the accept cycle.
// Reset is synchronous; the cursor returns to column 0, row 0.
// A stalled output holds the sequencer; s_tready is high only when idle.
module text_console_cell_writer_top #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tccw_pkg::S_TDATA_W-1:0]    s_tdata,  // value, hex_digits
    input  logic [tccw_pkg::ACTION_W-1:0]     s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tccw_pkg::M_TDATA_W-1:0]    m_tdata,  // cell_index, cell_value
    output logic                              m_tlast   // last_cell
);

    tccw_pkg::state_t                state_reg, state_next;
    logic [tccw_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic [2:0]                      nib_reg, nib_next;
    logic [tccw_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                            m_tvalid_reg;
    logic [tccw_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                            m_tlast_reg;

    logic                            s_accept;
    logic                            out_free;
    logic                            out_load;
    logic [tccw_pkg::CHAR_W-1:0]     out_char;
    logic                            out_last;
    logic [tccw_pkg::VALUE_W-1:0]    in_value;
    logic [tccw_pkg::HEXCNT_W-1:0]   in_hexcnt;
    tccw_pkg::action_t               in_action;
    logic [2:0]                      hex_top;
    logic [tccw_pkg::INDEX_W-1:0]    cell_index;
    tccw_pkg::cur_ctrl_t             cur_ctrl;
    tccw_pkg::dec_ctrl_t             dec_ctrl;
    tccw_pkg::dec_stat_t             dec_stat;

    assign in_value  = s_tdata[tccw_pkg::VALUE_W-1:0];
    assign in_hexcnt = s_tdata[tccw_pkg::VALUE_W +: tccw_pkg::HEXCNT_W];
    assign in_action = tccw_pkg::action_t'(s_tuser);
    assign s_tready  = (state_reg == tccw_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign hex_top   = (in_hexcnt == '0 || in_hexcnt > 4'd8) ? 3'd7 : 3'(in_hexcnt - 4'd1);

    tccw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (cur_ctrl),
        .cell_index (cell_index)
    );

    tccw_dec_unit u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (dec_ctrl),
        .load_value (in_value),
        .stat       (dec_stat)
    );

    // Hold the state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tccw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        nib_reg   <= nib_next;
        char_reg  <= char_next;
    end

    // Sequence the cell writes of one item
    always_comb begin
        state_next       = state_reg;
        value_next       = value_reg;
        nib_next         = nib_reg;
        char_next        = char_reg;
        out_load         = 1'b0;
        out_char         = char_reg;
        out_last         = 1'b0;
        cur_ctrl.advance = 1'b0;
        cur_ctrl.newline = 1'b0;
        dec_ctrl.load    = 1'b0;
        dec_ctrl.step    = 1'b0;
        case (state_reg)
            tccw_pkg::ST_IDLE: begin
                if (s_accept) begin
                    value_next = in_value;
                    nib_next   = hex_top;
                    char_next  = in_value[tccw_pkg::CHAR_W-1:0];
                    case (in_action)
                        tccw_pkg::ACT_CHAR: begin
                            if (in_value[tccw_pkg::CHAR_W-1:0] == tccw_pkg::NEWLINE) begin
                                cur_ctrl.newline = 1'b1;
                            end else begin
                                state_next = tccw_pkg::ST_CHAR;
                            end
                        end
                        tccw_pkg::ACT_HEX: begin
                            state_next = tccw_pkg::ST_PFX0;
                        end
                        tccw_pkg::ACT_DEC: begin
                            dec_ctrl.load = 1'b1;
                            state_next    = tccw_pkg::ST_DEC;
                        end
                        default: begin
                            state_next = tccw_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tccw_pkg::ST_CHAR: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_char         = char_reg;
                    out_last         = 1'b1;
                    cur_ctrl.advance = 1'b1;
                    state_next       = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_PFX0: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_char         = tccw_pkg::CHAR_ZERO;
                    cur_ctrl.advance = 1'b1;
                    state_next       = tccw_pkg::ST_PFXX;
                end
            end
            tccw_pkg::ST_PFXX: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_char         = tccw_pkg::CHAR_X;
                    cur_ctrl.advance = 1'b1;
                    state_next       = tccw_pkg::ST_HEX;
                end
            end
            tccw_pkg::ST_HEX: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    out_char         = tccw_pkg::hex_glyph(value_reg[{nib_reg, 2'b00} +: 4]);
                    out_last         = (nib_reg == '0);
                    cur_ctrl.advance = 1'b1;
                    nib_next         = nib_reg - 1'b1;
                    if (nib_reg == '0) begin
                        state_next = tccw_pkg::ST_IDLE;
                    end
                end
            end
            tccw_pkg::ST_DEC: begin
                if (out_free) begin
                    dec_ctrl.step = 1'b1;
                    out_char      = tccw_pkg::CHAR_ZERO | {4'h0, dec_stat.digit};
                    out_last      = dec_stat.last;
                    if (dec_stat.emit) begin
                        out_load         = 1'b1;
                        cur_ctrl.advance = 1'b1;
                    end
                    if (dec_stat.last) begin
                        state_next = tccw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: load a cell write or drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= tccw_pkg::M_TDATA_W'({tccw_pkg::ATTRIBUTE, out_char, cell_index});
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A hex item always starts with its prefix
    a_hex_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_action == tccw_pkg::ACT_HEX |=> state_reg == tccw_pkg::ST_PFX0)
        else $error("hex item did not start with prefix");

    // The last cell of an item returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && out_last |=> state_reg == tccw_pkg::ST_IDLE)
        else $error("sequencer busy after last cell");

endmodule

>>> tb/sv/text_console_cell_writer_top_test.sv
// Self-checking bench for the text console cell writer: streamed items, cursor predictor.
`timescale 1ns / 1ps

module text_console_cell_writer_top_test;

    localparam int COLUMNS     = tccw_pkg::COLUMNS_DEF;
    localparam int ROWS        = tccw_pkg::ROWS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF    = 400;
    localparam int SETTLE      = 100;
    localparam int RAND_ITEMS  = 32;
    localparam logic [tccw_pkg::CHAR_W-1:0] GLYPH_A = 8'h41;

    // One frame-buffer write as the block should emit it
    typedef struct packed {
        logic [tccw_pkg::INDEX_W-1:0] index;
        logic [tccw_pkg::CELL_W-1:0]  value;
        logic                         last;
    } cell_write_t;

    // Cursor predictor and the queue of cell writes still owed by the block
    class console_cell_scoreboard;
        cell_write_t expected_cells[$];
        int          cursor_col;
        int          cursor_row;
        int          mismatches;

        function new();
            cursor_col = 0;
            cursor_row = 0;
            mismatches = 0;
        endfunction

        function void next_row();
            cursor_col = 0;
            cursor_row = (cursor_row + 1 >= ROWS) ? 0 : cursor_row + 1;
        endfunction

        // Work out the cell writes that one accepted item causes
        function void note_item(tccw_pkg::action_t act,
                                logic [tccw_pkg::VALUE_W-1:0] val,
                                logic [tccw_pkg::HEXCNT_W-1:0] digits);
            logic [tccw_pkg::CHAR_W-1:0]  glyphs[$];
            logic [tccw_pkg::VALUE_W-1:0] rest;
            logic [3:0]                   nib;
            int                           count;
            cell_write_t                  wr;
            int                           pos;
            case (act)
                tccw_pkg::ACT_CHAR: begin
                    if (val[7:0] == tccw_pkg::NEWLINE) begin
                        next_row();
                    end else begin
                        glyphs.push_back(val[7:0]);
                    end
                end
                tccw_pkg::ACT_HEX: begin
                    count = (digits == 0 || digits > 8) ? 8 : int'(digits);
                    glyphs.push_back(tccw_pkg::CHAR_ZERO);
                    glyphs.push_back(tccw_pkg::CHAR_X);
                    for (int i = count - 1; i >= 0; i--) begin
                        nib = val[i*4 +: 4];
                        glyphs.push_back(nib < 4'd10 ? tccw_pkg::CHAR_ZERO + {4'h0, nib}
                                                     : GLYPH_A + {4'h0, nib} - 8'd10);
                    end
                end
                tccw_pkg::ACT_DEC: begin
                    // most significant digit ends up in front
                    rest = val;
                    do begin
                        glyphs.push_front(tccw_pkg::CHAR_ZERO + 8'(rest % 10));
                        rest = rest / 10;
                    end while (rest != 0);
                end
                default: begin
                end
            endcase
            foreach (glyphs[i]) begin
                pos      = cursor_row * COLUMNS + cursor_col;
                wr.index = pos[tccw_pkg::INDEX_W-1:0];
                wr.value = {tccw_pkg::ATTRIBUTE, glyphs[i]};
                wr.last  = (i == glyphs.size() - 1);
                expected_cells.push_back(wr);
                cursor_col++;
                if (cursor_col >= COLUMNS) begin
                    next_row();
                end
            end
        endfunction

        // Compare one accepted cell write with the oldest one owed
        function void check_cell(logic [tccw_pkg::M_TDATA_W-1:0] tdata, logic tlast);
            cell_write_t want;
            if (expected_cells.size() == 0) begin
                $error("unexpected cell write: cell_index %0d cell_value %h last_cell %0b",
                       tdata[10:0], tdata[26:11], tlast);
                mismatches++;
                return;
            end
            want = expected_cells.pop_front();
            if (tdata[10:0] != want.index) begin
                $error("cell_index: expected %0d, actual %0d", want.index, tdata[10:0]);
                mismatches++;
            end
            if (tdata[26:11] != want.value) begin
                $error("cell_value: expected %h, actual %h", want.value, tdata[26:11]);
                mismatches++;
            end
            if (tlast != want.last) begin
                $error("last_cell: expected %0b, actual %0b", want.last, tlast);
                mismatches++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tccw_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [tccw_pkg::ACTION_W-1:0]   s_tuser  = tccw_pkg::ACT_CHAR;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tccw_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;

    console_cell_scoreboard board = new();
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    text_console_cell_writer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hold reset at first, then release for good
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Give up on a hung block
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Check accepted cell writes; stall at random or through a hold-off
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            board.check_cell(m_tdata, m_tlast);
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one item, idling first at random, and predict it once accepted
    task automatic send_item(input tccw_pkg::action_t act,
                             input logic [tccw_pkg::VALUE_W-1:0] val,
                             input logic [tccw_pkg::HEXCNT_W-1:0] digits);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, digits, val};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        board.note_item(act, val, digits);
    endtask

    // Stop offering until every owed cell write has come back
    task automatic wait_cells_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.expected_cells.size() != 0);
    endtask

    // Field extremes, every action, newline, saturation, ignored code, row wrap
    task automatic run_directed();
        send_item(tccw_pkg::ACT_CHAR, 32'h0000_0041, 4'd0);
        send_item(tccw_pkg::ACT_CHAR, 32'h0000_0000, 4'd15);
        send_item(tccw_pkg::ACT_CHAR, 32'h0000_00FF, 4'd0);
        send_item(tccw_pkg::ACT_CHAR, 32'hFFFF_FF80, 4'd7);
        send_item(tccw_pkg::ACT_CHAR, {24'h0, tccw_pkg::NEWLINE}, 4'd0);
        send_item(tccw_pkg::ACT_CHAR, {24'hABCDEF, tccw_pkg::NEWLINE}, 4'd0);
        send_item(tccw_pkg::ACT_HEX, 32'h0000_0000, 4'd0);
        send_item(tccw_pkg::ACT_HEX, 32'hFFFF_FFFF, 4'd8);
        send_item(tccw_pkg::ACT_HEX, 32'h89AB_CDEF, 4'd1);
        send_item(tccw_pkg::ACT_HEX, 32'h1234_5678, 4'd9);
        send_item(tccw_pkg::ACT_HEX, 32'h0F1E_2D3C, 4'd15);
        send_item(tccw_pkg::ACT_DEC, 32'd0, 4'd0);
        send_item(tccw_pkg::ACT_DEC, 32'd9, 4'd0);
        send_item(tccw_pkg::ACT_DEC, 32'd10, 4'd5);
        send_item(tccw_pkg::ACT_DEC, 32'hFFFF_FFFF, 4'd0);
        send_item(tccw_pkg::ACT_DEC, 32'd1000000000, 4'd0);
        send_item(tccw_pkg::ACT_NONE, 32'hFFFF_FFFF, 4'd15);
        send_item(tccw_pkg::ACT_CHAR, {24'h0, tccw_pkg::NEWLINE}, 4'd0);
        // eight full hex numbers fill a row exactly and move the cursor to the next
        for (int i = 0; i < 8; i++) begin
            send_item(tccw_pkg::ACT_HEX, $urandom, 4'd0);
        end
    endtask

    // Random items; ignored codes do not count toward the total
    task automatic run_random(input int count);
        int                            sent;
        int                            pick;
        tccw_pkg::action_t             act;
        logic [tccw_pkg::VALUE_W-1:0]  val;
        logic [tccw_pkg::HEXCNT_W-1:0] digits;
        sent = 0;
        while (sent < count) begin
            pick   = $urandom_range(99);
            val    = $urandom;
            digits = 4'($urandom_range(15));
            if (pick < 45) begin
                act = tccw_pkg::ACT_CHAR;
                if ($urandom_range(99) < 40) begin
                    val[7:0] = tccw_pkg::NEWLINE;
                end
            end else if (pick < 70) begin
                act = tccw_pkg::ACT_HEX;
                if ($urandom_range(9) == 0) begin
                    val = ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                end
            end else if (pick < 95) begin
                act  = tccw_pkg::ACT_DEC;
                pick = $urandom_range(9);
                if (pick < 5) begin
                    val = $urandom_range(999);
                end else if (pick < 8) begin
                    val = $urandom_range(99999999);
                end
            end else begin
                act = tccw_pkg::ACT_NONE;
            end
            send_item(act, val, digits);
            if (act != tccw_pkg::ACT_NONE) begin
                sent++;
            end
        end
    endtask

    // Phases of idling on either side, then drain and report
    initial begin
        do @(posedge aclk); while (!aresetn);

        // no idling; receiver holds off long enough to back the block up
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_OFF;
        run_directed();
        run_random(RAND_ITEMS);

        // sender idles often, then pauses until all cell writes are back
        src_idle_pct = 60;
        run_random(RAND_ITEMS);
        wait_cells_drained();

        // receiver stalls often
        src_idle_pct   = 0;
        sink_stall_pct = 60;
        run_random(RAND_ITEMS);

        // light idling on both sides
        src_idle_pct   = 10;
        sink_stall_pct = 10;
        run_random(RAND_ITEMS);

        wait_cells_drained();
        repeat (SETTLE) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
